[rtl/core/erp_pkg.sv]
// shared constants and types for the euler rotation times projection unit
package erp_pkg;

  localparam int TRIG_FRAC_BITS_DEF = 16;

  // angle formats: signed Q9.16 input, reduced angle in [0, 360) degrees
  localparam int ANG_W   = 26;
  localparam int RED_W   = 28;
  localparam int ANG_U_W = 25;
  localparam int FRC_W   = 23;

  typedef logic [ANG_U_W-1:0] ang_t;

  localparam logic [ANG_U_W-1:0] DEG90  = 25'd5898240;
  localparam logic [ANG_U_W-1:0] DEG180 = 25'd11796480;
  localparam logic [ANG_U_W-1:0] DEG270 = 25'd17694720;

  localparam logic signed [RED_W-1:0] RED_360 = 28'sd23592960;
  localparam logic signed [RED_W-1:0] RED_720 = 28'sd47185920;

  // degrees to radians in Q46, split at bit 32
  localparam logic [31:0] DEG2RAD_LO = 32'd4100597034;
  localparam logic [8:0]  DEG2RAD_HI = 9'd285;

  // taylor series of the base sine
  localparam int NUM_TERMS = 7;
  localparam int DIV_SHIFT = 33;
  localparam int SIN_LAT   = 5 + 3 * NUM_TERMS + 1;

  // configuration and result formats
  localparam int NUM_PAIRS = 8;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_W     = 64;
  localparam int ENT_W     = 32;
  localparam int IDX_W     = 4;

  localparam logic [IDX_W-1:0] ENTRY_LAST = '1;

  localparam logic signed [ENT_W-1:0] SAT_MAX = 32'sh7fffffff;
  localparam logic signed [ENT_W-1:0] SAT_MIN = 32'sh80000000;

  localparam logic [CFG_W-1:0] PROJ_RST [NUM_PAIRS] = '{
    64'd65536, 64'd0, 64'd281474976710656, 64'd0,
    64'd0, 64'd65536, 64'd0, 64'd281474976710656
  };

endpackage

[rtl/core/erp_sin.sv]
// pipelined fixed-point sine of an angle in [0, 360) degrees
module erp_sin #(
  parameter int TRIG_FRAC_BITS = erp_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            en,
  input  erp_pkg::ang_t                   ang,
  output logic signed [TRIG_FRAC_BITS+1:0] sine
);
  import erp_pkg::*;

  localparam int SH = 30 - TRIG_FRAC_BITS;
  localparam logic [32:0] HALF = (33'd1 << SH) >> 1;

  // quadrant split
  logic [FRC_W-1:0] f_c, f1, g2;
  logic             odd_c, neg_c, odd1, neg1, neg2, neg3, neg4, neg5;
  logic [54:0]      plo3;
  logic [31:0]      phi3;
  logic [30:0]      x4;
  logic [61:0]      xx;
  logic [31:0]      x2_5, sum5;
  logic [30:0]      t5;

  logic [32:0] ta_p   [NUM_TERMS];
  logic [31:0] ta_x2  [NUM_TERMS];
  logic [31:0] ta_sum [NUM_TERMS];
  logic        ta_neg [NUM_TERMS];
  logic [32:0] tb_p   [NUM_TERMS];
  logic [30:0] tb_qe  [NUM_TERMS];
  logic [31:0] tb_x2  [NUM_TERMS];
  logic [31:0] tb_sum [NUM_TERMS];
  logic        tb_neg [NUM_TERMS];
  logic [30:0] tc_t   [NUM_TERMS];
  logic [31:0] tc_x2  [NUM_TERMS];
  logic [31:0] tc_sum [NUM_TERMS];
  logic        tc_neg [NUM_TERMS];

  logic [32:0]             rnd;
  logic [TRIG_FRAC_BITS:0] mag;

  always_comb begin
    if (ang >= DEG270) begin
      f_c = FRC_W'(ang - DEG270); odd_c = 1'b1; neg_c = 1'b1;
    end else if (ang >= DEG180) begin
      f_c = FRC_W'(ang - DEG180); odd_c = 1'b0; neg_c = 1'b1;
    end else if (ang >= DEG90) begin
      f_c = FRC_W'(ang - DEG90);  odd_c = 1'b1; neg_c = 1'b0;
    end else begin
      f_c = FRC_W'(ang);          odd_c = 1'b0; neg_c = 1'b0;
    end
  end

  assign xx = 62'(x4) * 62'(x4);

  always_ff @(posedge clk) begin
    if (en) begin
      f1   <= f_c;
      odd1 <= odd_c;
      neg1 <= neg_c;
      g2   <= odd1 ? FRC_W'(DEG90) - f1 : f1;
      neg2 <= neg1;
      plo3 <= 55'(g2) * 55'(DEG2RAD_LO);
      phi3 <= 32'(g2) * 32'(DEG2RAD_HI);
      neg3 <= neg2;
      x4   <= 31'(phi3) + 31'(plo3[54:32]);
      neg4 <= neg3;
      x2_5 <= xx[61:30];
      t5   <= x4;
      sum5 <= 32'(x4);
      neg5 <= neg4;
    end
  end

  // each term: multiply by x^2, divide by (2k)(2k+1) via reciprocal, one correction
  for (genvar i = 0; i < NUM_TERMS; i++) begin : g_term
    localparam longint unsigned Dv  = 64'((2 * (i + 1)) * (2 * (i + 1) + 1));
    localparam longint unsigned Mv  = (64'd1 << DIV_SHIFT) / Dv;
    localparam bit              SUB = (i % 2) == 0;

    logic [30:0] t_in;
    logic [31:0] x2_in, sum_in;
    logic        neg_in;
    logic [62:0] tx;
    logic [63:0] pm;
    logic [38:0] qd;
    logic [33:0] rem;
    logic [30:0] qt;

    if (i == 0) begin : g_first
      assign t_in   = t5;
      assign x2_in  = x2_5;
      assign sum_in = sum5;
      assign neg_in = neg5;
    end else begin : g_next
      assign t_in   = tc_t[i-1];
      assign x2_in  = tc_x2[i-1];
      assign sum_in = tc_sum[i-1];
      assign neg_in = tc_neg[i-1];
    end

    assign tx  = 63'(t_in) * 63'(x2_in);
    assign pm  = 64'(ta_p[i]) * 64'(Mv);
    assign qd  = 39'(tb_qe[i]) * 39'(Dv);
    assign rem = 34'(tb_p[i]) - 34'(qd);
    assign qt  = tb_qe[i] + 31'(rem >= 34'(Dv));

    always_ff @(posedge clk) begin
      if (en) begin
        ta_p[i]   <= tx[62:30];
        ta_x2[i]  <= x2_in;
        ta_sum[i] <= sum_in;
        ta_neg[i] <= neg_in;
        tb_p[i]   <= ta_p[i];
        tb_qe[i]  <= pm[63:33];
        tb_x2[i]  <= ta_x2[i];
        tb_sum[i] <= ta_sum[i];
        tb_neg[i] <= ta_neg[i];
        tc_t[i]   <= qt;
        tc_x2[i]  <= tb_x2[i];
        tc_sum[i] <= SUB ? tb_sum[i] - 32'(qt) : tb_sum[i] + 32'(qt);
        tc_neg[i] <= tb_neg[i];
      end
    end
  end

  assign rnd = 33'(tc_sum[NUM_TERMS-1]) + HALF;
  assign mag = (TRIG_FRAC_BITS+1)'(rnd >> SH);

  always_ff @(posedge clk) begin
    if (en) begin
      sine <= tc_neg[NUM_TERMS-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

endmodule

[rtl/core/euler_rotation_times_projection_unit.sv]
// euler angle rotation matrix times configured projection, one entry per cycle unless stalled
// first entry path: front pipeline, hold registers, stages b0, b1, b2, output register
// throughput: one entry per cycle unless stalled; the 16-entry issue loop paces the inputs
// the front pipeline (angle reduction, six sine lanes, matrix build) takes an item each cycle
// while in_stall is low; reset clears all valid state and loads the identity projection
module euler_rotation_times_projection_unit #(
  parameter int TRIG_FRAC_BITS = erp_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [erp_pkg::ANG_W-1:0]     pitch_deg,
  input  logic signed [erp_pkg::ANG_W-1:0]     yaw_deg,
  input  logic signed [erp_pkg::ANG_W-1:0]     roll_deg,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [erp_pkg::IDX_W-1:0]            entry_index,
  output logic signed [erp_pkg::ENT_W-1:0]     entry_value,
  output logic                                 last_entry,
  input  logic                                 cfg_write,
  input  logic [erp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [erp_pkg::CFG_W-1:0]            cfg_data
);
  import erp_pkg::*;

  localparam int TW     = TRIG_FRAC_BITS + 2;
  localparam int PW     = 2 * TW;
  localparam int RW     = TRIG_FRAC_BITS + 3;
  localparam int BW     = RW + ENT_W;
  localparam int TMW    = BW - TRIG_FRAC_BITS + 1;
  localparam int SW     = TMW + 2;
  localparam int FE_LAT = 3 + SIN_LAT + 5;

  localparam logic [PW-1:0] TRIG_HALF = PW'(1) << (TRIG_FRAC_BITS - 1);
  localparam logic [BW-1:0] ENT_HALF  = BW'(1) << (TRIG_FRAC_BITS - 1);
  localparam logic signed [RW-1:0] ONE = RW'(1) << TRIG_FRAC_BITS;

  // trig lanes
  localparam int L_SX = 0, L_CX = 1, L_SY = 2, L_CY = 3, L_SZ = 4, L_CZ = 5;
  // two-factor products
  localparam int P_CYCZ = 0, P_CXSZ = 1, P_SXSZ = 2, P_CYSZ = 3, P_CXCZ = 4;
  localparam int P_SXCZ = 5, P_SXCY = 6, P_CXCY = 7, P_SXSY = 8, P_CXSY = 9;
  localparam int NP2 = 10;
  localparam int NQ2 = 8;

  function automatic logic [TW-1:0] mag_trig(input logic signed [TW-1:0] v);
    return v[TW-1] ? TW'(-v) : TW'(v);
  endfunction

  function automatic logic signed [TW-1:0] rnd_trig(input logic [PW-1:0] m, input logic n);
    logic [PW-1:0] s;
    logic [TW-1:0] q;
    s = m + TRIG_HALF;
    q = TW'(s >> TRIG_FRAC_BITS);
    return n ? -$signed(q) : $signed(q);
  endfunction

  // ---------------- handshake and front pipeline control
  logic fe_en, be_en, accept, load, issue, last_issue, hold_free, fr_valid;
  logic hold_valid;
  logic [IDX_W-1:0] cnt;
  logic [FE_LAT-1:0] vld;

  assign be_en      = !out_valid || !out_stall;
  assign issue      = be_en && hold_valid;
  assign last_issue = issue && (cnt == ENTRY_LAST);
  assign hold_free  = !hold_valid || last_issue;
  assign fr_valid   = vld[FE_LAT-1];
  assign load       = fr_valid && hold_free;
  assign fe_en      = !fr_valid || load;
  assign in_stall   = !fe_en;
  assign accept     = in_valid && fe_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (fe_en) begin
      vld <= {vld[FE_LAT-2:0], accept};
    end
  end

  // ---------------- angle capture and reduction
  logic signed [ANG_W-1:0] a0 [3];
  ang_t r1 [3];
  ang_t v2 [6];
  logic signed [RED_W-1:0] ax [3];
  logic signed [RED_W-1:0] rr [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ax[i] = RED_W'(a0[i]);
      if (ax[i] < -RED_360) begin
        rr[i] = ax[i] + RED_720;
      end else if (ax[i] < 0) begin
        rr[i] = ax[i] + RED_360;
      end else if (ax[i] >= RED_360) begin
        rr[i] = ax[i] - RED_360;
      end else begin
        rr[i] = ax[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fe_en) begin
      a0[0] <= pitch_deg;
      a0[1] <= yaw_deg;
      a0[2] <= roll_deg;
      for (int i = 0; i < 3; i++) begin
        r1[i]       <= ANG_U_W'(rr[i]);
        v2[2*i]     <= r1[i];
        // cosine as sine of the angle plus a quarter turn
        v2[2*i + 1] <= (r1[i] >= DEG270) ? r1[i] - DEG270 : r1[i] + DEG90;
      end
    end
  end

  // ---------------- sine lanes
  logic signed [TW-1:0] trig [6];

  for (genvar j = 0; j < 6; j++) begin : g_sin
    erp_sin #(
      .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
    ) u_sin (
      .clk (clk),
      .en  (fe_en),
      .ang (v2[j]),
      .sine(trig[j])
    );
  end

  // ---------------- rotation matrix build
  logic signed [TW-1:0] opa [NP2];
  logic signed [TW-1:0] opb [NP2];

  always_comb begin
    opa[P_CYCZ] = trig[L_CY]; opb[P_CYCZ] = trig[L_CZ];
    opa[P_CXSZ] = trig[L_CX]; opb[P_CXSZ] = trig[L_SZ];
    opa[P_SXSZ] = trig[L_SX]; opb[P_SXSZ] = trig[L_SZ];
    opa[P_CYSZ] = trig[L_CY]; opb[P_CYSZ] = trig[L_SZ];
    opa[P_CXCZ] = trig[L_CX]; opb[P_CXCZ] = trig[L_CZ];
    opa[P_SXCZ] = trig[L_SX]; opb[P_SXCZ] = trig[L_CZ];
    opa[P_SXCY] = trig[L_SX]; opb[P_SXCY] = trig[L_CY];
    opa[P_CXCY] = trig[L_CX]; opb[P_CXCY] = trig[L_CY];
    opa[P_SXSY] = trig[L_SX]; opb[P_SXSY] = trig[L_SY];
    opa[P_CXSY] = trig[L_CX]; opb[P_CXSY] = trig[L_SY];
  end

  logic [PW-1:0]        r1_mag [NP2];
  logic                 r1_neg [NP2];
  logic signed [TW-1:0] r1_sy, r1_sz, r1_cz;
  logic signed [TW-1:0] r2_q [NP2];
  logic signed [TW-1:0] r2_sy, r2_sz, r2_cz;
  logic [PW-1:0]        r3_mag [4];
  logic                 r3_neg [4];
  logic signed [TW-1:0] r3_q2 [NQ2];
  logic signed [TW-1:0] r3_sy;
  logic signed [TW-1:0] r4_q3 [4];
  logic signed [TW-1:0] r4_q2 [NQ2];
  logic signed [TW-1:0] r4_sy;
  logic signed [TW-1:0] op3a [4];
  logic signed [TW-1:0] op3b [4];
  logic signed [RW-1:0] rn [16];
  logic [4*RW-1:0]      fr_row [4];

  // three-factor terms: (sx*sy)*cz, (sx*sy)*sz, (cx*sy)*cz, (cx*sy)*sz
  always_comb begin
    op3a[0] = r2_q[P_SXSY]; op3b[0] = r2_cz;
    op3a[1] = r2_q[P_SXSY]; op3b[1] = r2_sz;
    op3a[2] = r2_q[P_CXSY]; op3b[2] = r2_cz;
    op3a[3] = r2_q[P_CXSY]; op3b[3] = r2_sz;
  end

  always_ff @(posedge clk) begin
    if (fe_en) begin
      for (int i = 0; i < NP2; i++) begin
        r1_mag[i] <= PW'(mag_trig(opa[i])) * PW'(mag_trig(opb[i]));
        r1_neg[i] <= opa[i][TW-1] ^ opb[i][TW-1];
        r2_q[i]   <= rnd_trig(r1_mag[i], r1_neg[i]);
      end
      r1_sy <= trig[L_SY];
      r1_sz <= trig[L_SZ];
      r1_cz <= trig[L_CZ];
      r2_sy <= r1_sy;
      r2_sz <= r1_sz;
      r2_cz <= r1_cz;
      for (int i = 0; i < 4; i++) begin
        r3_mag[i] <= PW'(mag_trig(op3a[i])) * PW'(mag_trig(op3b[i]));
        r3_neg[i] <= op3a[i][TW-1] ^ op3b[i][TW-1];
        r4_q3[i]  <= rnd_trig(r3_mag[i], r3_neg[i]);
      end
      for (int i = 0; i < NQ2; i++) begin
        r3_q2[i] <= r2_q[i];
        r4_q2[i] <= r3_q2[i];
      end
      r3_sy <= r2_sy;
      r4_sy <= r3_sy;
      for (int i = 0; i < 4; i++) begin
        fr_row[i] <= {rn[4*i + 3], rn[4*i + 2], rn[4*i + 1], rn[4*i]};
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      rn[i] = '0;
    end
    rn[0]  = RW'(r4_q2[P_CYCZ]);
    rn[1]  = RW'(r4_q3[0]) - RW'(r4_q2[P_CXSZ]);
    rn[2]  = RW'(r4_q3[2]) + RW'(r4_q2[P_SXSZ]);
    rn[4]  = RW'(r4_q2[P_CYSZ]);
    rn[5]  = RW'(r4_q3[1]) + RW'(r4_q2[P_CXCZ]);
    rn[6]  = RW'(r4_q3[3]) - RW'(r4_q2[P_SXCZ]);
    rn[8]  = -RW'(r4_sy);
    rn[9]  = RW'(r4_q2[P_SXCY]);
    rn[10] = RW'(r4_q2[P_CXCY]);
    rn[15] = ONE;
  end

  // ---------------- configuration
  logic [CFG_W-1:0] proj [NUM_PAIRS];

  always_ff @(posedge clk) begin
    if (rst) begin
      proj <= PROJ_RST;
    end else if (cfg_write && (cfg_index < CFG_IDX_W'(NUM_PAIRS))) begin
      proj[cfg_index[$clog2(NUM_PAIRS)-1:0]] <= cfg_data;
    end
  end

  // ---------------- hold and issue
  logic [4*RW-1:0] hold_row [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      cnt        <= '0;
    end else begin
      if (issue) begin
        cnt <= cnt + IDX_W'(1);
      end
      if (load) begin
        hold_valid <= 1'b1;
      end else if (last_issue) begin
        hold_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold_row <= fr_row;
    end
  end

  // ---------------- entry pipeline
  logic [4*RW-1:0]           sel_row;
  logic [2*CFG_W-1:0]        prow [4];
  logic signed [RW-1:0]      b0n_ra [4];
  logic signed [ENT_W-1:0]   b0n_pb [4];
  logic signed [RW-1:0]      b0_ra [4];
  logic signed [ENT_W-1:0]   b0_pb [4];
  logic [IDX_W-1:0]          b0_idx, b1_idx, b2_idx;
  logic                      b0_v, b1_v, b2_v;
  logic [BW-1:0]             b1_mag [4];
  logic                      b1_neg [4];
  logic signed [TMW-1:0]     b2_t [4];
  logic [RW-1:0]             ma [4];
  logic [ENT_W-1:0]          mb [4];
  logic [BW-1:0]             bs [4];
  logic [TMW-1:0]            bq [4];
  logic signed [SW-1:0]      esum;

  always_comb begin
    sel_row = hold_row[cnt[3:2]];
    for (int k = 0; k < 4; k++) begin
      prow[k]   = {proj[2*k + 1], proj[2*k]};
      b0n_ra[k] = $signed(sel_row[k*RW +: RW]);
      b0n_pb[k] = $signed(prow[k][cnt[1:0]*ENT_W +: ENT_W]);
      ma[k]     = b0_ra[k][RW-1] ? RW'(-b0_ra[k]) : RW'(b0_ra[k]);
      mb[k]     = b0_pb[k][ENT_W-1] ? ENT_W'(-b0_pb[k]) : ENT_W'(b0_pb[k]);
      bs[k]     = b1_mag[k] + ENT_HALF;
      bq[k]     = TMW'(bs[k] >> TRIG_FRAC_BITS);
    end
    esum = '0;
    for (int k = 0; k < 4; k++) begin
      esum = esum + SW'(b2_t[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b0_v      <= 1'b0;
      b1_v      <= 1'b0;
      b2_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (be_en) begin
      b0_v      <= hold_valid;
      b1_v      <= b0_v;
      b2_v      <= b1_v;
      out_valid <= b2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (be_en) begin
      b0_idx <= cnt;
      b1_idx <= b0_idx;
      b2_idx <= b1_idx;
      for (int k = 0; k < 4; k++) begin
        b0_ra[k]  <= b0n_ra[k];
        b0_pb[k]  <= b0n_pb[k];
        b1_mag[k] <= BW'(ma[k]) * BW'(mb[k]);
        b1_neg[k] <= b0_ra[k][RW-1] ^ b0_pb[k][ENT_W-1];
        b2_t[k]   <= b1_neg[k] ? -$signed(bq[k]) : $signed(bq[k]);
      end
      entry_index <= b2_idx;
      last_entry  <= (b2_idx == ENTRY_LAST);
      if (esum > SW'(SAT_MAX)) begin
        entry_value <= SAT_MAX;
      end else if (esum < SW'(SAT_MIN)) begin
        entry_value <= SAT_MIN;
      end else begin
        entry_value <= esum[ENT_W-1:0];
      end
    end
  end

  // ---------------- checks
  a_stall_holds_cnt: assert property (@(posedge clk) disable iff (rst)
    !be_en |=> $stable(cnt))
    else $error("issue counter moved while the entry pipeline was stalled");

  a_front_kept: assert property (@(posedge clk) disable iff (rst)
    fr_valid && !fe_en |=> fr_valid)
    else $error("finished rotation matrix dropped before it was taken");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> (!hold_valid || (cnt == ENTRY_LAST)))
    else $error("matrix loaded over one with entries still to issue");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> vld[0])
    else $error("accepted transaction did not enter the pipeline");

endmodule
